@@ rtl/core/cgpm_pkg.sv @@
// Shared codes and fixed field widths of the channel gain peak meter.
`timescale 1ns / 1ps

package cgpm_pkg;

  localparam int CH_W       = 6;
  localparam int GAIN_W     = 16;
  localparam int DECAY_W    = 16;
  localparam int HOLD_W     = 8;
  localparam int ACT_W      = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 8'd3;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd16384;
  localparam logic [DECAY_W-1:0] DECAY_RST  = 16'd62259;
  localparam logic [HOLD_W-1:0]  HOLD_RST   = 8'd24;
  localparam logic [ACT_W-1:0]   ACTIVE_RST = 7'd54;

  // input operation and result kind codes
  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_BLOCK_END = 1'b1;
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_METER   = 1'b1;

  // fraction bits of the Q1.15 gain, the shift applied to the gain product
  localparam int GAIN_FRAC = 15;

endpackage

@@ rtl/core/cgpm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cgpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/channel_gain_peak_meter_top.sv @@
// Top level: multichannel gain stage with per-channel peak meter and peak hold.
// Sample word: accept and store read, multiply, then round and block max writeback
//   into the result register; the input stalls until that word is loaded there.
// Block end: per metered channel a store read, a decay multiply and a writeback, in
//   turn, after the accept; the input stalls until the last channel is loaded.
// Reset: registers take their defaults, valid bits clear all channel state at once.
`timescale 1ns / 1ps

module channel_gain_peak_meter_top
  import cgpm_pkg::*;
#(
  parameter int CHANNELS    = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [CH_W-1:0]              channel,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic [CH_W-1:0]              out_channel,
  output logic signed [SAMPLE_BITS-1:0] scaled_sample,
  output logic [SAMPLE_BITS-2:0]       level,
  output logic [SAMPLE_BITS-2:0]       peak,
  output logic                         last
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAG_W  = SAMPLE_BITS - 1;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int SMAG_W = SAMPLE_BITS + 1;
  localparam int MT_W   = 2 * MAG_W + HOLD_W;

  localparam logic [MAG_W-1:0]  MAG_MAX  = {MAG_W{1'b1}};
  localparam logic [SMAG_W-1:0] NEG_MAX  = SMAG_W'(1) << MAG_W;
  localparam logic [PROD_W-1:0] ROUND    = PROD_W'(1) << (GAIN_FRAC - 1);
  localparam logic [ACT_W-1:0]  CH_LIMIT = ACT_W'(CHANNELS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SMP  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  logic [2:0]         state;
  logic [GAIN_W-1:0]  gain_q15;
  logic [DECAY_W-1:0] decay_factor;
  logic [HOLD_W-1:0]  hold_blocks;
  logic [ACT_W-1:0]   active_channels;
  logic [CHANNELS-1:0] bm_valid;
  logic [CHANNELS-1:0] mt_valid;
  logic [AW-1:0]      cnt;
  logic [ACT_W-1:0]   n_act;
  logic               o_valid;

  // sample path
  logic                  s_neg;
  logic [SAMPLE_BITS-1:0] s_amag;
  logic [CH_W-1:0]       ch_reg;
  logic                  ch_ok;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     prod_rnd;
  logic [SMAG_W-1:0]     smag;
  logic [SMAG_W-1:0]     smag_neg;
  logic [SAMPLE_BITS-1:0] scaled_val;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W-1:0]      bm_old;

  // meter path
  logic [MAG_W-1:0]  lvl_dec;
  logic [MAG_W-1:0]  pk_dec;
  logic [MAG_W-1:0]  m_cur;
  logic [MAG_W-1:0]  lvl_old;
  logic [MAG_W-1:0]  pk_old;
  logic [HOLD_W-1:0] hold_old;
  logic [MAG_W-1:0]  lvl_new;
  logic [MAG_W-1:0]  pk_new;
  logic [HOLD_W-1:0] hold_new;
  logic [MAG_W+DECAY_W-1:0] lvl_prod;
  logic [MAG_W+DECAY_W-1:0] pk_prod;
  logic              walk_last;

  // memories
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic             bm_we;
  logic [MAG_W-1:0] bm_rdata;
  logic             mt_we;
  logic [MT_W-1:0]  mt_wdata;
  logic [MT_W-1:0]  mt_rdata;

  logic in_take;
  logic out_free;
  logic o_load;
  logic [ACT_W-1:0] n_in;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !o_valid || !out_stall;
  assign out_valid = o_valid;
  assign o_load    = ((state == ST_SMP) || (state == ST_WB)) && out_free;

  assign n_in = (active_channels > CH_LIMIT) ? CH_LIMIT : active_channels;

  assign ram_re    = in_take || (state == ST_RD);
  assign ram_raddr = (state == ST_IDLE) ? channel[AW-1:0] : cnt;

  // round to nearest, ties away from zero, then saturate per sign
  assign prod_rnd = prod + ROUND;
  assign smag     = prod_rnd[PROD_W-1:GAIN_FRAC];
  assign smag_neg = (smag > NEG_MAX) ? NEG_MAX : smag;
  assign scaled_val = s_neg ? (SAMPLE_BITS'(0) - smag_neg[SAMPLE_BITS-1:0])
                            : ((smag > SMAG_W'(MAG_MAX)) ? {1'b0, MAG_MAX}
                                                         : smag[SAMPLE_BITS-1:0]);
  assign mag    = (smag > SMAG_W'(MAG_MAX)) ? MAG_MAX : smag[MAG_W-1:0];
  assign bm_old = (ch_ok && bm_valid[ch_reg[AW-1:0]]) ? bm_rdata : '0;
  assign bm_we  = (state == ST_SMP) && out_free && ch_ok && (mag > bm_old);

  // entries without a valid bit read as zero
  assign m_cur    = bm_valid[cnt] ? bm_rdata : '0;
  assign lvl_old  = mt_valid[cnt] ? mt_rdata[MAG_W-1:0] : '0;
  assign pk_old   = mt_valid[cnt] ? mt_rdata[2*MAG_W-1:MAG_W] : '0;
  assign hold_old = mt_valid[cnt] ? mt_rdata[MT_W-1:2*MAG_W] : '0;
  assign lvl_prod = (MAG_W+DECAY_W)'(lvl_old) * (MAG_W+DECAY_W)'(decay_factor);
  assign pk_prod  = (MAG_W+DECAY_W)'(pk_old) * (MAG_W+DECAY_W)'(decay_factor);

  always_comb begin
    lvl_new  = (m_cur > lvl_dec) ? m_cur : lvl_dec;
    pk_new   = pk_old;
    hold_new = hold_old;
    if (m_cur > pk_old) begin
      pk_new   = m_cur;
      hold_new = hold_blocks;
    end else if (hold_old != '0) begin
      hold_new = hold_old - 1'b1;
    end else begin
      pk_new = pk_dec;
    end
  end

  assign walk_last = (ACT_W'(cnt) + 1'b1) == n_act;
  assign mt_we     = (state == ST_WB) && out_free;
  assign mt_wdata  = {hold_new, pk_new, lvl_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      o_valid         <= 1'b0;
      gain_q15        <= GAIN_RST;
      decay_factor    <= DECAY_RST;
      hold_blocks     <= HOLD_RST;
      active_channels <= ACTIVE_RST;
      bm_valid        <= '0;
      mt_valid        <= '0;
      cnt             <= '0;
      n_act           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GAIN:   gain_q15        <= cfg_data;
          CFG_DECAY:  decay_factor    <= cfg_data;
          CFG_HOLD:   hold_blocks     <= cfg_data[HOLD_W-1:0];
          CFG_ACTIVE: active_channels <= cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (!out_stall) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (operation == OP_SAMPLE) begin
              state <= ST_MUL;
            end else if (n_in == '0) begin
              bm_valid <= '0;
            end else begin
              n_act <= n_in;
              cnt   <= '0;
              state <= ST_RD;
            end
          end
        end
        ST_MUL: state <= ST_SMP;
        ST_SMP: begin
          if (out_free) begin
            if (bm_we) begin
              bm_valid[ch_reg[AW-1:0]] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_RD:  state <= ST_DEC;
        ST_DEC: state <= ST_WB;
        ST_WB: begin
          if (out_free) begin
            mt_valid[cnt] <= 1'b1;
            if (walk_last) begin
              // every block max restarts, metered or not
              bm_valid <= '0;
              state    <= ST_IDLE;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_neg  <= sample[SAMPLE_BITS-1];
      s_amag <= sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - sample) : sample;
      ch_reg <= channel;
      ch_ok  <= {1'b0, channel} < CH_LIMIT;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(s_amag) * PROD_W'(gain_q15);
    end
    if (state == ST_DEC) begin
      lvl_dec <= lvl_prod[MAG_W+DECAY_W-1:DECAY_W];
      pk_dec  <= pk_prod[MAG_W+DECAY_W-1:DECAY_W];
    end
    if ((state == ST_SMP) && out_free) begin
      kind          <= KIND_SAMPLE;
      out_channel   <= ch_reg;
      scaled_sample <= scaled_val;
      level         <= '0;
      peak          <= '0;
      last          <= 1'b1;
    end else if ((state == ST_WB) && out_free) begin
      kind          <= KIND_METER;
      out_channel   <= CH_W'(cnt);
      scaled_sample <= '0;
      level         <= lvl_new;
      peak          <= pk_new;
      last          <= walk_last;
    end
  end

  cgpm_ram #(
    .WIDTH (MAG_W),
    .DEPTH (CHANNELS)
  ) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (ch_reg[AW-1:0]),
    .wdata (mag),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (bm_rdata)
  );

  cgpm_ram #(
    .WIDTH (MT_W),
    .DEPTH (CHANNELS)
  ) u_mt_ram (
    .clk   (clk),
    .we    (mt_we),
    .waddr (cnt),
    .wdata (mt_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (mt_rdata)
  );

endmodule

@@ rtl/core/cgpm_checker.sv @@
// Port-level checks on the result channel of the gain peak meter, bound to the top.
`timescale 1ns / 1ps

module cgpm_checker
  import cgpm_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         kind,
  input logic [CH_W-1:0]              out_channel,
  input logic signed [SAMPLE_BITS-1:0] scaled_sample,
  input logic [SAMPLE_BITS-2:0]       level,
  input logic [SAMPLE_BITS-2:0]       peak,
  input logic                         last
);

  // a stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_channel)
      && $stable(scaled_sample) && $stable(level) && $stable(peak) && $stable(last))
    else $error("stalled result word changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SAMPLE) |-> (level == '0) && (peak == '0) && last)
    else $error("sample result carries meter fields");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_METER) |-> (scaled_sample == '0))
    else $error("meter result carries a sample");

  // reset drops any pending word
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind channel_gain_peak_meter_top cgpm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);

@@ bench/channel_gain_peak_meter_checker.sv @@
// Checker for the channel gain peak meter: predicts every result word and compares.
`timescale 1ns / 1ps

module channel_gain_peak_meter_checker
  import cgpm_pkg::*;
#(
  parameter int CHANNELS    = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          operation,
  input  logic [CH_W-1:0]               channel,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          kind,
  input  logic [CH_W-1:0]               out_channel,
  input  logic signed [SAMPLE_BITS-1:0] scaled_sample,
  input  logic [SAMPLE_BITS-2:0]        level,
  input  logic [SAMPLE_BITS-2:0]        peak,
  input  logic                          last,
  output int                            pending,
  output int                            fail_count
);

  localparam int MAG_W = SAMPLE_BITS - 1;
  localparam logic [63:0] MAG_LIMIT = (64'd1 << MAG_W) - 64'd1;
  localparam logic [63:0] NEG_LIMIT = 64'd1 << MAG_W;

  typedef struct {
    logic                          kind;
    logic [CH_W-1:0]               chan;
    logic signed [SAMPLE_BITS-1:0] scaled;
    logic [MAG_W-1:0]              lvl;
    logic [MAG_W-1:0]              pk;
    logic                          last;
  } meter_word_t;

  meter_word_t expected_words[$];

  logic [GAIN_W-1:0]  gain_q15;
  logic [DECAY_W-1:0] decay_q16;
  logic [HOLD_W-1:0]  hold_reload;
  logic [ACT_W-1:0]   active_cnt;

  logic [MAG_W-1:0]  blk_max  [CHANNELS];
  logic [MAG_W-1:0]  lvl_mem  [CHANNELS];
  logic [MAG_W-1:0]  pk_mem   [CHANNELS];
  logic [HOLD_W-1:0] hold_cnt [CHANNELS];

  initial fail_count = 0;

  task automatic report(input string what, input logic [CH_W-1:0] chan,
                        input logic [63:0] got, input logic [63:0] want);
    $display("cgpm_checker: %0t %s on channel %0d: got %0h, expected %0h",
             $time, what, chan, got, want);
    fail_count++;
  endtask

  function automatic logic [MAG_W-1:0] decayed(input logic [MAG_W-1:0] x);
    logic [MAG_W+DECAY_W-1:0] prod;
    prod = x * decay_q16;
    return prod[MAG_W+DECAY_W-1:DECAY_W];
  endfunction

  task automatic scale_word(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_BITS-1:0] s);
    logic                   neg;
    logic [SAMPLE_BITS-1:0] amag;
    logic [63:0]            smag;
    logic [MAG_W-1:0]       mag;
    meter_word_t            w;
    neg  = s[SAMPLE_BITS-1];
    amag = neg ? (~s + 1'b1) : s;
    smag = ((64'(amag) * 64'(gain_q15)) + 64'd16384) >> GAIN_FRAC;
    if (neg) begin
      if (smag > NEG_LIMIT) smag = NEG_LIMIT;
      w.scaled = SAMPLE_BITS'(64'd0 - smag);
    end else begin
      if (smag > MAG_LIMIT) smag = MAG_LIMIT;
      w.scaled = smag[SAMPLE_BITS-1:0];
    end
    mag = (smag > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : smag[MAG_W-1:0];
    if (int'(ch) < CHANNELS && mag > blk_max[ch]) blk_max[ch] = mag;
    w.kind = KIND_SAMPLE;
    w.chan = ch;
    w.lvl  = '0;
    w.pk   = '0;
    w.last = 1'b1;
    expected_words.push_back(w);
  endtask

  task automatic close_block();
    int               n;
    int               c;
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] lv;
    meter_word_t      w;
    n = (int'(active_cnt) > CHANNELS) ? CHANNELS : int'(active_cnt);
    for (c = 0; c < n; c++) begin
      m  = blk_max[c];
      lv = decayed(lvl_mem[c]);
      if (m > lv) lv = m;
      lvl_mem[c] = lv;
      if (m > pk_mem[c]) begin
        pk_mem[c]   = m;
        hold_cnt[c] = hold_reload;
      end else if (hold_cnt[c] != '0) begin
        hold_cnt[c] = hold_cnt[c] - 1'b1;
      end else begin
        pk_mem[c] = decayed(pk_mem[c]);
      end
      w.kind   = KIND_METER;
      w.chan   = c[CH_W-1:0];
      w.scaled = '0;
      w.lvl    = lvl_mem[c];
      w.pk     = pk_mem[c];
      w.last   = (c == n - 1);
      expected_words.push_back(w);
    end
    // unmetered channels lose their block max too
    for (c = 0; c < CHANNELS; c++) blk_max[c] = '0;
  endtask

  task automatic check_word();
    meter_word_t w;
    if (expected_words.size() == 0) begin
      report("result word with none expected", out_channel, 64'(kind), 64'(KIND_SAMPLE));
    end else begin
      w = expected_words.pop_front();
      if (kind !== w.kind) report("kind", w.chan, 64'(kind), 64'(w.kind));
      if (out_channel !== w.chan) report("out_channel", w.chan, 64'(out_channel), 64'(w.chan));
      if (scaled_sample !== w.scaled)
        report("scaled_sample", w.chan, 64'(scaled_sample), 64'(w.scaled));
      if (level !== w.lvl) report("level", w.chan, 64'(level), 64'(w.lvl));
      if (peak !== w.pk) report("peak", w.chan, 64'(peak), 64'(w.pk));
      if (last !== w.last) report("last", w.chan, 64'(last), 64'(w.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gain_q15    = GAIN_RST;
      decay_q16   = DECAY_RST;
      hold_reload = HOLD_RST;
      active_cnt  = ACTIVE_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        blk_max[c]  = '0;
        lvl_mem[c]  = '0;
        pk_mem[c]   = '0;
        hold_cnt[c] = '0;
      end
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN:   gain_q15    = cfg_data[GAIN_W-1:0];
          CFG_DECAY:  decay_q16   = cfg_data[DECAY_W-1:0];
          CFG_HOLD:   hold_reload = cfg_data[HOLD_W-1:0];
          CFG_ACTIVE: active_cnt  = cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (operation == OP_SAMPLE) scale_word(channel, sample);
        else close_block();
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ bench/tb_channel_gain_peak_meter_top.sv @@
// Testbench top for the channel gain peak meter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_channel_gain_peak_meter_top;
  import cgpm_pkg::*;

  localparam int CHANNELS    = 64;
  localparam int SAMPLE_BITS = 24;
  localparam int LIMIT       = 500000;
  localparam int SETTLE      = 400;
  localparam int BURST_LEN   = 200;
  localparam int PHASE_WORDS = 68;
  // register index that decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd200;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          operation = OP_SAMPLE;
  logic [CH_W-1:0]               channel = '0;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          kind;
  logic [CH_W-1:0]               out_channel;
  logic signed [SAMPLE_BITS-1:0] scaled_sample;
  logic [SAMPLE_BITS-2:0]        level;
  logic [SAMPLE_BITS-2:0]        peak;
  logic                          last;

  int mismatches;
  int results_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int burst_req = 0;
  int burst_seen = 0;
  int burst_left = 0;
  int act_now = 54;
  int cycle_cnt = 0;

  always #1 clk = ~clk;

  channel_gain_peak_meter_top #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .channel       (channel),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .out_channel   (out_channel),
    .scaled_sample (scaled_sample),
    .level         (level),
    .peak          (peak),
    .last          (last)
  );

  channel_gain_peak_meter_checker #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .channel       (channel),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .out_channel   (out_channel),
    .scaled_sample (scaled_sample),
    .level         (level),
    .peak          (peak),
    .last          (last),
    .pending       (results_pending),
    .fail_count    (mismatches)
  );

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (burst_req != burst_seen) begin
      burst_seen <= burst_req;
      burst_left <= BURST_LEN;
      out_stall  <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_channel_gain_peak_meter_top: errors");
    $finish;
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send_word(input logic op, input logic [CH_W-1:0] ch,
                           input logic signed [SAMPLE_BITS-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    channel   <= ch;
    sample    <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic end_block();
    send_word(OP_BLOCK_END, CH_W'($urandom), SAMPLE_BITS'($urandom));
  endtask

  // hold off until every result word is in and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ACTIVE) begin
      act_now = int'(data[ACT_W-1:0]);
      if (act_now > CHANNELS) act_now = CHANNELS;
    end
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic [31:0] r;
    int          sh;
    r  = $urandom;
    sh = $urandom_range(0, SAMPLE_BITS - 1);
    case ($urandom_range(3))
      0: return r[SAMPLE_BITS-1:0];
      1: return $signed(r[SAMPLE_BITS-1:0]) >>> sh;
      2: begin
        case ($urandom_range(3))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $signed(r[SAMPLE_BITS-1:0]) >>> 8;
    endcase
  endfunction

  task automatic random_config();
    logic [GAIN_W-1:0]  g;
    logic [DECAY_W-1:0] d;
    logic [HOLD_W-1:0]  h;
    logic [ACT_W-1:0]   a;
    case ($urandom_range(4))
      0: g = '0;
      1: g = 16'd32768;
      2: g = '1;
      default: g = GAIN_W'($urandom_range(8192, 49152));
    endcase
    case ($urandom_range(3))
      0: d = '0;
      1: d = '1;
      default: d = DECAY_W'($urandom_range(30000, 65535));
    endcase
    h = ($urandom_range(4) == 0) ? 8'd255 : 8'($urandom_range(0, 5));
    case ($urandom_range(3))
      0: a = 7'd64;
      1: a = 7'd1;
      default: a = 7'($urandom_range(2, 63));
    endcase
    write_reg(CFG_GAIN, g);
    write_reg(CFG_DECAY, d);
    write_reg(CFG_HOLD, {8'($urandom), h});
    write_reg(CFG_ACTIVE, {9'($urandom), a});
  endtask

  // mostly samples on metered channels, a block end now and then
  task automatic run_phase(input bit with_burst);
    logic [CH_W-1:0] ch;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (with_burst && i == 8) burst_req++;
      if ($urandom_range(9) == 0) begin
        end_block();
      end else begin
        if (act_now == 0 || $urandom_range(7) == 0) ch = CH_W'($urandom_range(CHANNELS - 1));
        else ch = CH_W'($urandom_range(act_now - 1));
        send_word(OP_SAMPLE, ch, pick_sample());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idling(16, 62);

    // reset configuration, full-scale and tiny samples, hold countdown
    send_word(OP_SAMPLE, 6'd0, S_MAX);
    send_word(OP_SAMPLE, 6'd63, S_MIN);
    send_word(OP_SAMPLE, 6'd5, '0);
    send_word(OP_SAMPLE, 6'd1, -24'sd1);
    send_word(OP_SAMPLE, 6'd2, 24'sd1);
    end_block();
    end_block();
    drain();

    // gain above unity saturates, zero decay, no hold, all channels metered
    write_reg(CFG_GAIN, 16'hFFFF);
    write_reg(CFG_DECAY, 16'h0000);
    write_reg(CFG_HOLD, 16'h0000);
    write_reg(CFG_ACTIVE, 16'd64);
    send_word(OP_SAMPLE, 6'd63, S_MAX);
    send_word(OP_SAMPLE, 6'd0, S_MIN);
    send_word(OP_SAMPLE, 6'd10, -24'sd3);
    send_word(OP_SAMPLE, 6'd62, 24'sd256);
    end_block();
    end_block();
    drain();

    // zero gain, slowest decay, longest hold
    write_reg(CFG_GAIN, 16'h0000);
    write_reg(CFG_DECAY, 16'hFFFF);
    write_reg(CFG_HOLD, 16'hFFFF);
    send_word(OP_SAMPLE, 6'd4, S_MAX);
    drain();

    // no metered channels: block end yields nothing but still clears
    write_reg(CFG_GAIN, 16'd32768);
    write_reg(CFG_ACTIVE, 16'hFF80);
    send_word(OP_SAMPLE, 6'd3, 24'sd1000);
    end_block();
    drain();

    // count above the channel total is clipped
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(CFG_ACTIVE, 16'hFFFF);
    send_word(OP_SAMPLE, 6'd2, -24'sd5);
    end_block();
    drain();

    // one metered channel; channel 1 stays unmetered
    write_reg(CFG_ACTIVE, 16'd1);
    send_word(OP_SAMPLE, 6'd0, 24'sd7);
    send_word(OP_SAMPLE, 6'd1, 24'sd9);
    end_block();
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: set_idling(16, 62);
        1: set_idling(62, 16);
        default: set_idling(0, 0);
      endcase
      random_config();
      run_phase(p == 1);
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_channel_gain_peak_meter_top: clean");
    end else begin
      $display("tb_channel_gain_peak_meter_top: errors");
    end
    $finish;
  end

endmodule
